### sv/fst_pkg.sv
// Shared types, codes and constants for the frame stage timer.
`default_nettype none

package fst_pkg;

  localparam int TIME_WIDTH_DEF = 64;
  localparam int RATE_W         = 30;
  localparam int REFRESH_W      = 10;
  localparam int DIM_W          = 16;
  localparam int TS_W           = 64;
  localparam int RES_W          = 64;
  localparam int OP_W           = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 30;

  localparam logic [RATE_W-1:0]    NS_PER_SEC    = 30'd1000000000;
  localparam logic [RATE_W-1:0]    TICK_RATE_RST = 30'd1000000000;
  localparam logic [REFRESH_W-1:0] REFRESH_RST   = 10'd60;
  localparam logic [DIM_W-1:0]     WIDTH_RST     = 16'd1920;
  localparam logic [DIM_W-1:0]     HEIGHT_RST    = 16'd1080;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN   = 2'd0,
    OP_SCENE   = 2'd1,
    OP_RASTER  = 2'd2,
    OP_PRESENT = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_RATE      = 2'd0,
    REG_REFRESH_RATE   = 2'd1,
    REG_SURFACE_WIDTH  = 2'd2,
    REG_SURFACE_HEIGHT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [RATE_W-1:0]    tick_rate;
    logic [REFRESH_W-1:0] refresh_rate;
    logic                 valid;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic budget;
  } span_req_t;

  typedef struct packed {
    logic done;
    logic fail;
  } span_rsp_t;

  typedef enum logic [1:0] {
    SP_IDLE,
    SP_MUL,
    SP_DIV,
    SP_DONE
  } span_ph_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_LAUNCH,
    C_RUN1,
    C_SECOND,
    C_RUN2,
    C_DONE
  } ctrl_st_t;

endpackage

`default_nettype wire

### sv/fst_if.sv
// Handshake interfaces for the event, result and configuration channels.
`default_nettype none

interface fst_in_if;
  import fst_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [TS_W-1:0]   timestamp;
  modport source (output valid, operation, timestamp, input ready);
  modport sink (input valid, operation, timestamp, output ready);
endinterface

interface fst_out_if;
  import fst_pkg::*;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [RES_W-1:0]  stage_duration_ns;
  logic              frame_complete;
  logic              over_budget;
  logic              fits_budget;
  logic [RATE_W-1:0] budget_ns;
  modport source (output valid, ok, stage_duration_ns, frame_complete, over_budget,
                  fits_budget, budget_ns, input ready);
  modport sink (input valid, ok, stage_duration_ns, frame_complete, over_budget,
                fits_budget, budget_ns, output ready);
endinterface

interface fst_cfg_if;
  import fst_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/fst_cfg_regs.sv
// Configuration register file with the validity check used at frame begin.
`default_nettype none

module fst_cfg_regs (
  input  logic         clk,
  input  logic         rst_n,
  fst_cfg_if.sink      cfg_bus,
  output fst_pkg::cfg_t cfg
);
  import fst_pkg::*;

  logic [RATE_W-1:0]    tick_rate_r;
  logic [REFRESH_W-1:0] refresh_r;
  logic [DIM_W-1:0]     width_r;
  logic [DIM_W-1:0]     height_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r <= TICK_RATE_RST;
      refresh_r   <= REFRESH_RST;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
    end else if (cfg_bus.valid) begin
      unique case (reg_idx_t'(cfg_bus.index))
        REG_TICK_RATE:      tick_rate_r <= cfg_bus.data[RATE_W-1:0];
        REG_REFRESH_RATE:   refresh_r   <= cfg_bus.data[REFRESH_W-1:0];
        REG_SURFACE_WIDTH:  width_r     <= cfg_bus.data[DIM_W-1:0];
        REG_SURFACE_HEIGHT: height_r    <= cfg_bus.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.tick_rate    = tick_rate_r;
  assign cfg.refresh_rate = refresh_r;
  assign cfg.valid        = (tick_rate_r != '0) && (tick_rate_r <= NS_PER_SEC) &&
                            (refresh_r != '0) && (width_r != '0) && (height_r != '0);

endmodule

`default_nettype wire

### sv/fst_span_unit.sv
// Bit-serial span unit: (end-start)*1e9 or, for a budget, 1e9; restoring divide.
`default_nettype none

module fst_span_unit #(
  parameter int TIME_WIDTH = fst_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fst_pkg::span_req_t            req,
  input  logic [TIME_WIDTH-1:0]         end_tick,
  input  logic [TIME_WIDTH-1:0]         start_tick,
  input  logic [fst_pkg::RATE_W-1:0]    divisor,
  output fst_pkg::span_rsp_t            rsp,
  output logic [fst_pkg::RES_W-1:0]     quotient
);
  import fst_pkg::*;

  localparam int DW = TIME_WIDTH + RATE_W;
  localparam int CW = $clog2(DW + 1);

  span_ph_t ph_r, ph_nxt;

  logic [TIME_WIDTH-1:0] a_r, b_r, lo_r;
  logic                  brw_r, rev_r, ovf_r;
  logic [RATE_W-1:0]     acc_r, rem_r, dvs_r;
  logic [DW-1:0]         div_r;
  logic [RES_W-1:0]      q_r;
  logic [CW-1:0]         cnt_r;

  logic                  last;
  logic                  d_bit, brw_nxt, ge;
  logic [RATE_W:0]       sum, rr, diff;

  assign last    = (cnt_r == CW'(1));
  assign d_bit   = a_r[0] ^ b_r[0] ^ brw_r;
  assign brw_nxt = (~a_r[0] & b_r[0]) | (~(a_r[0] ^ b_r[0]) & brw_r);
  assign sum     = {1'b0, acc_r} + (d_bit ? {1'b0, NS_PER_SEC} : {(RATE_W + 1){1'b0}});
  assign rr      = {rem_r, div_r[DW-1]};
  assign ge      = (rr >= {1'b0, dvs_r});
  assign diff    = rr - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= SP_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      SP_IDLE: begin
        if (req.start) begin
          ph_nxt = req.budget ? SP_DIV : SP_MUL;
        end
      end
      SP_MUL: begin
        if (last) begin
          ph_nxt = SP_DIV;
        end
      end
      SP_DIV: begin
        if (last) begin
          ph_nxt = SP_DONE;
        end
      end
      SP_DONE: ph_nxt = SP_IDLE;
      default: ph_nxt = SP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case (ph_r)
        SP_IDLE: begin
          if (req.start) begin
            cnt_r <= req.budget ? CW'(DW) : CW'(TIME_WIDTH);
          end
        end
        SP_MUL: cnt_r <= last ? CW'(DW) : cnt_r - 1'b1;
        SP_DIV: cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ph_r)
      SP_IDLE: begin
        if (req.start) begin
          a_r   <= end_tick;
          b_r   <= start_tick;
          brw_r <= 1'b0;
          acc_r <= '0;
          dvs_r <= divisor;
          rem_r <= '0;
          q_r   <= '0;
          ovf_r <= 1'b0;
          rev_r <= 1'b0;
          div_r <= DW'(NS_PER_SEC);
        end
      end
      SP_MUL: begin
        a_r   <= a_r >> 1;
        b_r   <= b_r >> 1;
        brw_r <= brw_nxt;
        acc_r <= sum[RATE_W:1];
        lo_r  <= {sum[0], lo_r[TIME_WIDTH-1:1]};
        if (last) begin
          div_r <= {sum[RATE_W:1], sum[0], lo_r[TIME_WIDTH-1:1]};
          rev_r <= brw_nxt;
        end
      end
      SP_DIV: begin
        rem_r <= ge ? diff[RATE_W-1:0] : rr[RATE_W-1:0];
        div_r <= div_r << 1;
        q_r   <= {q_r[RES_W-2:0], ge};
        ovf_r <= ovf_r | q_r[RES_W-1];
      end
      default: ;
    endcase
  end

  assign rsp.done = (ph_r == SP_DONE);
  assign rsp.fail = rev_r | ovf_r;
  assign quotient = q_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == SP_DIV && dvs_r != '0) |-> (rem_r < dvs_r))
    else $error("division remainder reached the divisor");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == SP_MUL || ph_r == SP_DIV) |-> (cnt_r != '0))
    else $error("step counter empty during a serial pass");

  a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> ($past(ph_r) == SP_DIV))
    else $error("span finished without a division pass");

endmodule

`default_nettype wire

### sv/frame_stage_timer_unit.sv
// Top level of the frame stage timer: event sequencing, frame state and result register.
//
//   Channel  Port     Beat carries
//   event    in_bus   operation, timestamp
//   result   out_bus  ok, stage_duration_ns, frame_complete, over_budget, fits_budget, budget_ns
//   config   cfg_bus  index, data (always ready)
//
// Frame begin runs from one accepted event to the next through launch, the serial
// budget division, handoff, result and idle. Scene and raster add one bit-serial
// multiply pass. Present runs two such spans back to back.
// A failed check goes straight to the result.
// One event is in flight at a time; a finished result waits in the output register.
// Reset is synchronous and clears the frame state; no clearing pass is needed.
`default_nettype none

module frame_stage_timer_unit #(
  parameter int TIME_WIDTH = fst_pkg::TIME_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fst_in_if.sink     in_bus,
  fst_out_if.source  out_bus,
  fst_cfg_if.sink    cfg_bus
);
  import fst_pkg::*;

  ctrl_st_t st_r, st_nxt;

  cfg_t                  cfg;
  span_req_t             span_req;
  span_rsp_t             span_rsp;
  logic [RES_W-1:0]      span_q;
  logic [TIME_WIDTH-1:0] span_start;
  logic [RATE_W-1:0]     span_div;

  op_t                   op_r;
  logic [TIME_WIDTH-1:0] ts_r;
  logic                  frame_begun_r, scene_seen_r, raster_seen_r, complete_r;
  logic [TIME_WIDTH-1:0] begin_tick_r, scene_tick_r, raster_tick_r;
  logic [RATE_W-1:0]     rate_r, budget_r;
  logic [RES_W-1:0]      total_r, res_r;
  logic                  ok_r;

  logic                  out_valid_r, o_ok_r, o_cmp_r, o_over_r, o_fits_r;
  logic [RES_W-1:0]      o_dur_r;
  logic [RATE_W-1:0]     o_bud_r;

  logic                  launch_ok, commit, over_nxt;
  logic                  complete_nxt;
  logic [RATE_W-1:0]     budget_nxt;
  logic [RES_W-1:0]      total_nxt;

  fst_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  fst_span_unit #(.TIME_WIDTH(TIME_WIDTH)) u_span (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (span_req),
    .end_tick   (ts_r),
    .start_tick (span_start),
    .divisor    (span_div),
    .rsp        (span_rsp),
    .quotient   (span_q)
  );

  assign in_bus.ready = (st_r == C_IDLE);
  assign commit       = (st_r == C_DONE) && (!out_valid_r || out_bus.ready);

  always_comb begin
    unique case (op_r)
      OP_BEGIN:   launch_ok = cfg.valid;
      OP_SCENE:   launch_ok = frame_begun_r;
      OP_RASTER:  launch_ok = scene_seen_r;
      OP_PRESENT: launch_ok = raster_seen_r;
      default:    launch_ok = 1'b0;
    endcase
  end

  always_comb begin
    case (op_r)
      OP_SCENE:   span_start = begin_tick_r;
      OP_RASTER:  span_start = scene_tick_r;
      OP_PRESENT: span_start = (st_r == C_SECOND) ? begin_tick_r : raster_tick_r;
      default:    span_start = begin_tick_r;
    endcase
    span_div = (op_r == OP_BEGIN) ? RATE_W'(cfg.refresh_rate) : rate_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    span_req = '0;
    unique case (st_r)
      C_IDLE: begin
        if (in_bus.valid) begin
          st_nxt = C_LAUNCH;
        end
      end
      C_LAUNCH: begin
        if (launch_ok) begin
          span_req.start  = 1'b1;
          span_req.budget = (op_r == OP_BEGIN);
          st_nxt          = C_RUN1;
        end else begin
          st_nxt = C_DONE;
        end
      end
      C_RUN1: begin
        if (span_rsp.done) begin
          st_nxt = (!span_rsp.fail && op_r == OP_PRESENT) ? C_SECOND : C_DONE;
        end
      end
      C_SECOND: begin
        span_req.start = 1'b1;
        st_nxt         = C_RUN2;
      end
      C_RUN2: begin
        if (span_rsp.done) begin
          st_nxt = C_DONE;
        end
      end
      C_DONE: begin
        if (!out_valid_r || out_bus.ready) begin
          st_nxt = C_IDLE;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    complete_nxt = complete_r;
    budget_nxt   = budget_r;
    total_nxt    = total_r;
    if (ok_r) begin
      case (op_r)
        OP_BEGIN: begin
          complete_nxt = 1'b0;
          budget_nxt   = res_r[RATE_W-1:0];
          total_nxt    = '0;
        end
        OP_PRESENT: begin
          complete_nxt = 1'b1;
          total_nxt    = res_r;
        end
        default: ;
      endcase
    end
    over_nxt = (total_nxt > RES_W'(budget_nxt));
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      op_r <= op_t'(in_bus.operation);
      ts_r <= in_bus.timestamp[TIME_WIDTH-1:0];
    end
    if ((st_r == C_RUN1 || st_r == C_RUN2) && span_rsp.done) begin
      res_r <= span_q;
    end
    if (commit && ok_r) begin
      case (op_r)
        OP_BEGIN: begin
          begin_tick_r <= ts_r;
          rate_r       <= cfg.tick_rate;
        end
        OP_SCENE:  scene_tick_r  <= ts_r;
        OP_RASTER: raster_tick_r <= ts_r;
        default: ;
      endcase
    end
    if (commit) begin
      o_ok_r   <= ok_r;
      o_dur_r  <= (ok_r && op_r != OP_BEGIN) ? res_r : '0;
      o_cmp_r  <= complete_nxt;
      o_over_r <= complete_nxt && over_nxt;
      o_fits_r <= complete_nxt && !over_nxt;
      o_bud_r  <= budget_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r          <= 1'b0;
      frame_begun_r <= 1'b0;
      scene_seen_r  <= 1'b0;
      raster_seen_r <= 1'b0;
      complete_r    <= 1'b0;
      budget_r      <= '0;
      total_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (st_r == C_LAUNCH) begin
        ok_r <= launch_ok;
      end else if ((st_r == C_RUN1 || st_r == C_RUN2) && span_rsp.done && span_rsp.fail) begin
        ok_r <= 1'b0;
      end
      if (commit) begin
        complete_r <= complete_nxt;
        budget_r   <= budget_nxt;
        total_r    <= total_nxt;
        if (ok_r) begin
          case (op_r)
            OP_BEGIN: begin
              frame_begun_r <= 1'b1;
              scene_seen_r  <= 1'b0;
              raster_seen_r <= 1'b0;
            end
            OP_SCENE:  scene_seen_r  <= 1'b1;
            OP_RASTER: raster_seen_r <= 1'b1;
            default: ;
          endcase
        end
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.ok                = o_ok_r;
  assign out_bus.stage_duration_ns = o_dur_r;
  assign out_bus.frame_complete    = o_cmp_r;
  assign out_bus.over_budget       = o_over_r;
  assign out_bus.fits_budget       = o_fits_r;
  assign out_bus.budget_ns         = o_bud_r;

  a_complete_needs_stages: assert property (@(posedge clk) disable iff (!rst_n)
    complete_r |-> (frame_begun_r && scene_seen_r && raster_seen_r))
    else $error("frame complete without all earlier stages");

  a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!raster_seen_r || scene_seen_r) && (!scene_seen_r || frame_begun_r))
    else $error("stage flags out of order");

  a_complete_on_present: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(complete_r) |-> (op_r == OP_PRESENT))
    else $error("frame completed by an event other than present");

endmodule

`default_nettype wire
